// ===== rtl/lotd_pkg.sv =====
// Shared types and constants for the longest ordered trail block.
`timescale 1ns / 1ps
`default_nettype none
package lotd_pkg;

  localparam int VerticesDef   = 64;
  localparam int LengthBitsDef = 12;
  localparam int EndW          = 6;
  localparam int LongestW      = 12;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RD_B,
    ST_CALC,
    ST_WR_B,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;  // capture the input beat
    logic sel_b;      // read port addresses end B instead of end A
    logic cap_la;     // register length of end A from read data
    logic wr_a;       // write new end A length, note it
    logic wr_b;       // write new end B length, note it
    logic clr_run;    // zero running maximum and saturation flag
    logic idx_rst;    // restart the clear sweep
    logic clr_step;   // write zero at sweep index, advance
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_edge;
    logic in_range;
    logic clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lotd_ctrl.sv =====
// Sequencing state machine for the longest ordered trail block.
`timescale 1ns / 1ps
`default_nettype none
module lotd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire lotd_pkg::dp_stat_t stat_i,
  output lotd_pkg::dp_cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import lotd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        // sweep after reset, no result beat
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_DONE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        // read of end A is issued here
        if (!stat_i.is_edge) begin
          cmd_o.clr_run = 1'b1;
          cmd_o.idx_rst = 1'b1;
          state_d = ST_CLEAR;
        end else if (!stat_i.in_range) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RD_B;
        end
      end
      ST_RD_B: begin
        cmd_o.sel_b  = 1'b1;
        cmd_o.cap_la = 1'b1;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.wr_a = 1'b1;
        state_d = ST_WR_B;
      end
      ST_WR_B: begin
        cmd_o.wr_b = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lotd_dpath.sv =====
// Vertex length store, update arithmetic and running maximum.
`timescale 1ns / 1ps
`default_nettype none
module lotd_dpath #(
  parameter int Vertices   = lotd_pkg::VerticesDef,
  parameter int LengthBits = lotd_pkg::LengthBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lotd_pkg::dp_cmd_t               cmd_i,
  input  wire logic                            cmd_in_i,
  input  wire logic [lotd_pkg::EndW-1:0]       end_a_i,
  input  wire logic [lotd_pkg::EndW-1:0]       end_b_i,
  output lotd_pkg::dp_stat_t                   stat_o,
  output logic [lotd_pkg::LongestW-1:0]        longest_length_o,
  output logic                                 saturated_o
);
  import lotd_pkg::*;

  localparam int AW = (Vertices > 1) ? $clog2(Vertices) : 1;
  localparam logic [LengthBits-1:0] LenMax = '1;
  localparam logic [AW-1:0] LastIdx = AW'(Vertices - 1);

  logic [LengthBits-1:0] mem [Vertices];
  logic [LengthBits-1:0] rdata_q;
  logic [LengthBits-1:0] la_q;
  logic [LengthBits-1:0] nb_q;
  logic [LengthBits-1:0] run_q;
  logic                  sat_q;
  logic                  cmd_q;
  logic [EndW-1:0]       a_q, b_q;
  logic [AW-1:0]         idx_q;

  logic [AW-1:0]         raddr, waddr;
  logic [LengthBits-1:0] wdata, inc_la, inc_lb, na, nb, note_v;
  logic                  we, note_en;

  function automatic logic [LengthBits-1:0] sat_inc(input logic [LengthBits-1:0] v);
    return (v == LenMax) ? v : v + 1'b1;
  endfunction

  assign inc_la = sat_inc(la_q);
  assign inc_lb = sat_inc(rdata_q);
  assign na     = (la_q > inc_lb) ? la_q : inc_lb;
  assign nb     = (inc_la > rdata_q) ? inc_la : rdata_q;

  assign raddr = cmd_i.sel_b ? AW'(b_q) : AW'(a_q);

  always_comb begin
    we    = cmd_i.clr_step | cmd_i.wr_a | cmd_i.wr_b;
    waddr = idx_q;
    wdata = '0;
    if (cmd_i.wr_a) begin
      waddr = AW'(a_q);
      wdata = na;
    end else if (cmd_i.wr_b) begin
      waddr = AW'(b_q);
      wdata = nb_q;
    end
  end

  assign note_en = cmd_i.wr_a | cmd_i.wr_b;
  assign note_v  = cmd_i.wr_a ? na : nb_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q <= cmd_in_i;
      a_q   <= end_a_i;
      b_q   <= end_b_i;
    end
    if (cmd_i.cap_la) begin
      la_q <= rdata_q;
    end
    if (cmd_i.wr_a) begin
      nb_q <= nb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      run_q <= '0;
      sat_q <= 1'b0;
    end else begin
      if (cmd_i.idx_rst) begin
        idx_q <= '0;
      end else if (cmd_i.clr_step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.clr_run) begin
        run_q <= '0;
        sat_q <= 1'b0;
      end else if (note_en) begin
        if (note_v > run_q) begin
          run_q <= note_v;
        end
        if (note_v == LenMax) begin
          sat_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.is_edge  = cmd_q;
  assign stat_o.in_range = (32'(a_q) < 32'(Vertices)) && (32'(b_q) < 32'(Vertices));
  assign stat_o.clr_last = (idx_q == LastIdx);

  assign longest_length_o = LongestW'(run_q);
  assign saturated_o      = sat_q;

endmodule
`default_nettype wire

// ===== rtl/longest_ordered_trail_dp.sv =====
// An edge beat steps through DECODE, RD_B, CALC (writes end A) and WR_B, then
// gives its done strobe; an out-of-range edge goes from DECODE to done. One
// item at a time: busy stays high after acceptance through the done strobe.
// A clear sweeps the vertex store one entry per cycle, then strobes done.
// After reset the same sweep runs, busy high, with no result.
// The receiver cannot stall the done strobe.
`timescale 1ns / 1ps
`default_nettype none
module longest_ordered_trail_dp #(
  parameter int VERTICES    = lotd_pkg::VerticesDef,
  parameter int LENGTH_BITS = lotd_pkg::LengthBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cmd_i,
  input  wire logic [lotd_pkg::EndW-1:0]     end_a_i,
  input  wire logic [lotd_pkg::EndW-1:0]     end_b_i,
  output logic                               done_o,
  output logic [lotd_pkg::LongestW-1:0]      longest_length_o,
  output logic                               saturated_o
);
  import lotd_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  lotd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  lotd_dpath #(
    .Vertices  (VERTICES),
    .LengthBits(LENGTH_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .cmd_in_i        (cmd_i),
    .end_a_i         (end_a_i),
    .end_b_i         (end_b_i),
    .stat_o          (dp_stat),
    .longest_length_o(longest_length_o),
    .saturated_o     (saturated_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the longest ordered trail block: directed, long-trail and random edge beats.
`timescale 1ns / 1ps
module tb;
  import lotd_pkg::*;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;
  localparam int   NumVert   = VerticesDef;
  localparam int   LenW      = LengthBitsDef;
  localparam logic [LenW-1:0] LenTop = '1;
  localparam int   ClimbBeats  = 500;
  localparam int   RandomBeats = 1230;

  typedef struct packed {
    logic [LongestW-1:0] longest;
    logic                sat;
  } trail_result_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  logic                cmd_i   = CMD_CLEAR;
  logic [EndW-1:0]     end_a_i = '0;
  logic [EndW-1:0]     end_b_i = '0;
  logic                done_o;
  logic [LongestW-1:0] longest_length_o;
  logic                saturated_o;

  longest_ordered_trail_dp dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .end_a_i          (end_a_i),
    .end_b_i          (end_b_i),
    .done_o           (done_o),
    .longest_length_o (longest_length_o),
    .saturated_o      (saturated_o)
  );

  // predicted store, running maximum and sticky flag
  logic [LenW-1:0] trail_len [NumVert];
  logic [LenW-1:0] best_len;
  logic            seen_sat;

  // expected results in flight, small ring
  trail_result_t   want_buf [8];
  int unsigned     want_wr = 0;
  int unsigned     want_rd = 0;

  int unsigned mismatches    = 0;
  int unsigned beats_checked = 0;
  int unsigned edges_sent    = 0;
  int unsigned clears_sent   = 0;
  int unsigned peak_len      = 0;
  bit          idle_en       = 1'b1;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("FAIL longest_ordered_trail_dp");
    $finish;
  end

  function automatic logic [LenW-1:0] bump(input logic [LenW-1:0] v);
    return (v == LenTop) ? v : v + 1'b1;
  endfunction

  function automatic void note_len(input logic [LenW-1:0] v);
    if (v > best_len) best_len = v;
    if (v == LenTop) seen_sat = 1'b1;
  endfunction

  function automatic void clear_trails();
    foreach (trail_len[i]) trail_len[i] = '0;
    best_len = '0;
    seen_sat = 1'b0;
  endfunction

  function automatic void stash_want(input trail_result_t r);
    want_buf[3'(want_wr)] = r;
    want_wr++;
  endfunction

  function automatic trail_result_t advance_trails(input logic cmd,
                                                   input logic [EndW-1:0] a,
                                                   input logic [EndW-1:0] b);
    logic [LenW-1:0] la, lb, na, nb;
    trail_result_t   r;
    if (cmd == CMD_CLEAR) begin
      clear_trails();
    end else if (a < NumVert && b < NumVert) begin
      la = trail_len[a];
      lb = trail_len[b];
      if (a == b) begin
        na = bump(la);
        trail_len[a] = na;
        note_len(na);
      end else begin
        na = (la > bump(lb)) ? la : bump(lb);
        nb = (bump(la) > lb) ? bump(la) : lb;
        trail_len[a] = na;
        trail_len[b] = nb;
        note_len(na);
        note_len(nb);
      end
    end
    r.longest = best_len[LongestW-1:0];
    r.sat     = seen_sat;
    return r;
  endfunction

  // one beat; start is left high so a back-to-back beat never toggles it
  task automatic send_beat(input logic cmd, input logic [EndW-1:0] a,
                           input logic [EndW-1:0] b);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    cmd_i   <= cmd;
    end_a_i <= a;
    end_b_i <= b;
    do @(posedge clk_i); while (busy);
    stash_want(advance_trails(cmd, a, b));
    if (cmd == CMD_CLEAR) clears_sent++;
    else edges_sent++;
  endtask

  task automatic test_directed();
    idle_en = 1'b1;
    send_beat(CMD_CLEAR, 6'd63, 6'd63);
    send_beat(CMD_EDGE,  6'd0,  6'd63);
    send_beat(CMD_EDGE,  6'd63, 6'd0);
    send_beat(CMD_EDGE,  6'd63, 6'd63);
    send_beat(CMD_EDGE,  6'd0,  6'd0);
    send_beat(CMD_EDGE,  6'd0,  6'd1);
    send_beat(CMD_EDGE,  6'd1,  6'd0);
    send_beat(CMD_EDGE,  6'd42, 6'd21);
    send_beat(CMD_EDGE,  6'd21, 6'd42);
    send_beat(CMD_EDGE,  6'd63, 6'd42);
    send_beat(CMD_EDGE,  6'd1,  6'd63);
    send_beat(CMD_EDGE,  6'd21, 6'd21);
    send_beat(CMD_CLEAR, 6'd42, 6'd21);
    send_beat(CMD_EDGE,  6'd63, 6'd63);
    send_beat(CMD_EDGE,  6'd10, 6'd53);
    send_beat(CMD_CLEAR, 6'd0,  6'd0);
    send_beat(CMD_EDGE,  6'd53, 6'd10);
  endtask

  // self-loops build one long trail, then edges hang off the long vertex
  task automatic test_long_trail();
    send_beat(CMD_CLEAR, 6'd0, 6'd0);
    for (int n = 0; n < ClimbBeats; n++) begin
      if (n % 100 == 0) idle_en = 1'($urandom_range(0, 1));
      send_beat(CMD_EDGE, 6'd45, 6'd45);
    end
    idle_en = 1'b1;
    send_beat(CMD_EDGE,  6'd45, 6'd18);
    send_beat(CMD_EDGE,  6'd2,  6'd45);
    send_beat(CMD_EDGE,  6'd7,  6'd8);
    send_beat(CMD_CLEAR, 6'd45, 6'd45);
    send_beat(CMD_EDGE,  6'd45, 6'd18);
  endtask

  task automatic test_random();
    int unsigned     pick;
    logic [EndW-1:0] a, b;
    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 100 == 0) idle_en = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      a = EndW'($urandom);
      b = EndW'($urandom);
      if (pick < 3) begin
        send_beat(CMD_CLEAR, a, b);
      end else begin
        // a small hot set of vertices builds long trails
        if (pick < 60) begin
          a = EndW'($urandom_range(0, 7));
          b = EndW'($urandom_range(0, 7));
        end else if (pick < 70) begin
          b = a;
        end
        send_beat(CMD_EDGE, a, b);
      end
    end
  endtask

  always @(posedge clk_i) begin
    trail_result_t want;
    if (rst_ni && done_o) begin
      beats_checked++;
      if (longest_length_o > peak_len) peak_len = longest_length_o;
      if (want_wr == want_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat: longest %0d sat %0b",
                   $realtime, longest_length_o, saturated_o);
      end else begin
        want = want_buf[3'(want_rd)];
        want_rd++;
        if (longest_length_o !== want.longest || saturated_o !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: longest exp %0d got %0d, sat exp %0b got %0b",
                     $realtime, want.longest, longest_length_o, want.sat, saturated_o);
        end
      end
    end
  end

  initial begin
    clear_trails();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_trail();
    test_random();
    start <= 1'b0;
    while (want_wr != want_rd) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Ran %0d edge beats and %0d clears; %0d results checked, peak trail %0d",
             edges_sent, clears_sent, beats_checked, peak_len);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && want_wr == want_rd) begin
      $display("PASS longest_ordered_trail_dp");
    end else begin
      $display("FAIL longest_ordered_trail_dp");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lotd_pkg.sv
rtl/lotd_ctrl.sv
rtl/lotd_dpath.sv
rtl/longest_ordered_trail_dp.sv
tb/tb.sv
